/* design/rtlpm_pkg.sv */
`default_nettype none
package rtlpm_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int IFACE_COUNT = 32;

   localparam int IDX_W     = $clog2(TABLE_DEPTH);
   localparam int COUNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int IFACE_W   = 5;
   localparam int OUT_IDX_W = 5;
   localparam int ADDR_W    = 32;
   localparam int METRIC_W  = 16;
   localparam int STATUS_W  = 3;

   typedef enum logic {
      FUNC_LOOKUP = 1'b0,
      FUNC_INSERT = 1'b1
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_HIT      = 3'd0,
      ST_MISS     = 3'd1,
      ST_INSERTED = 3'd2,
      ST_PRESENT  = 3'd3,
      ST_CONFLICT = 3'd4,
      ST_FULL     = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_FINISH
   } state_type;

   // one route as held by a cell
   typedef struct packed {
      logic [ADDR_W-1:0]   subnet;
      logic [ADDR_W-1:0]   mask;
      logic [ADDR_W-1:0]   hop;
      logic [METRIC_W-1:0] metric;
      logic [IFACE_W-1:0]  iface;
      logic                dyn;
   } entry_type;

   // search broadcast to every cell while one transaction is in flight
   typedef struct packed {
      func_type           func;
      logic [ADDR_W-1:0]  key;
      logic [COUNT_W-1:0] count;
   } query_type;

   // running result handed from cell to cell
   typedef struct packed {
      logic             live;
      logic [IDX_W-1:0] pos;
      logic             hit;
      logic [IDX_W-1:0] hit_idx;
      entry_type        hit_entry;
   } token_type;

   // clamp an interface number to the configured interface range
   function automatic logic [IFACE_W-1:0] sat_iface(input logic [IFACE_W-1:0] v);
      logic [IFACE_W-1:0] r;
      r = v;
      if (int'(v) >= IFACE_COUNT) begin
         r = IFACE_W'(IFACE_COUNT - 1);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* design/rtlpm_req_if.sv */
`default_nettype none
interface rtlpm_req_if;
   logic                                valid;
   logic                                ready;
   logic                                func;
   logic [rtlpm_pkg::ADDR_W-1:0]        key_addr;
   logic [rtlpm_pkg::ADDR_W-1:0]        net_mask;
   logic [rtlpm_pkg::ADDR_W-1:0]        next_hop;
   logic [rtlpm_pkg::IFACE_W-1:0]       interface_index;
   logic                                dynamic_flag;
   logic [rtlpm_pkg::METRIC_W-1:0]      route_metric;

   modport source (
      output valid, func, key_addr, net_mask, next_hop, interface_index,
             dynamic_flag, route_metric,
      input  ready
   );
   modport sink (
      input  valid, func, key_addr, net_mask, next_hop, interface_index,
             dynamic_flag, route_metric,
      output ready
   );
endinterface
`default_nettype wire

/* design/rtlpm_rsp_if.sv */
`default_nettype none
interface rtlpm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [rtlpm_pkg::STATUS_W-1:0]      status;
   logic [rtlpm_pkg::OUT_IDX_W-1:0]     entry_index;
   logic [rtlpm_pkg::ADDR_W-1:0]        hop_out;
   logic [rtlpm_pkg::IFACE_W-1:0]       iface_out;
   logic [rtlpm_pkg::ADDR_W-1:0]        mask_out;
   logic [rtlpm_pkg::METRIC_W-1:0]      metric_out;
   logic                                dynamic_out;

   modport source (
      output valid, status, entry_index, hop_out, iface_out, mask_out,
             metric_out, dynamic_out,
      input  ready
   );
   modport sink (
      input  valid, status, entry_index, hop_out, iface_out, mask_out,
             metric_out, dynamic_out,
      output ready
   );
endinterface
`default_nettype wire

/* design/routing_table_lpm.sv */
// Flow: an accepted request is registered, the search token then passes through one
//   register per route cell, is captured at the end of the chain, and the finish step
//   loads the response register, waiting while an earlier response is not yet taken.
//   A new request is accepted only in idle, after the previous finish step.
// Reset: synchronous, active high; clears the route count, the FSM, the response valid
//   and the token live bits. Route storage is not cleared.
`default_nettype none
module routing_table_lpm (
   input  wire logic   clock,
   input  wire logic   reset,
   rtlpm_req_if.sink   req_bus,
   rtlpm_rsp_if.source rsp_bus
);

   // captured request payload
   typedef struct packed {
      rtlpm_pkg::func_type                 func;
      logic [rtlpm_pkg::ADDR_W-1:0]        key;
      logic [rtlpm_pkg::ADDR_W-1:0]        mask;
      logic [rtlpm_pkg::ADDR_W-1:0]        hop;
      logic [rtlpm_pkg::IFACE_W-1:0]       ifc;
      logic                                dyn;
      logic [rtlpm_pkg::METRIC_W-1:0]      metric;
   } item_type;

   // registered response payload
   typedef struct packed {
      rtlpm_pkg::status_type               status;
      logic [rtlpm_pkg::OUT_IDX_W-1:0]     idx;
      rtlpm_pkg::entry_type                entry;
   } rsp_type;

   rtlpm_pkg::state_type state_ff, state_in;

   item_type                          item_ff;
   logic [rtlpm_pkg::COUNT_W-1:0]     count_ff;
   logic                              start_ff;
   rtlpm_pkg::token_type              done_ff;
   rsp_type                           rsp_ff;
   rsp_type                           rsp_in;
   logic                              rsp_valid_ff;

   logic                              accept;
   logic                              capture_en;
   logic                              finish_go;
   logic                              append;
   logic                              wr_en;
   logic [rtlpm_pkg::IDX_W-1:0]       wr_idx;
   rtlpm_pkg::entry_type              new_entry;
   rtlpm_pkg::query_type              query;
   rtlpm_pkg::token_type              tok [rtlpm_pkg::TABLE_DEPTH+1];
   logic [rtlpm_pkg::TABLE_DEPTH-1:0] live_vec;

   assign accept = req_bus.valid && req_bus.ready;

   // ---------------------------------------------------------------------
   // FSM: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rtlpm_pkg::S_IDLE: begin
            if (accept) begin
               state_in = rtlpm_pkg::S_WALK;
            end
         end
         rtlpm_pkg::S_WALK: begin
            if (tok[rtlpm_pkg::TABLE_DEPTH].live) begin
               state_in = rtlpm_pkg::S_FINISH;
            end
         end
         rtlpm_pkg::S_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in = rtlpm_pkg::S_IDLE;
            end
         end
         default: state_in = rtlpm_pkg::S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // FSM: outputs
   // ---------------------------------------------------------------------
   always_comb begin
      req_bus.ready = 1'b0;
      capture_en    = 1'b0;
      finish_go     = 1'b0;
      unique case (state_ff)
         rtlpm_pkg::S_IDLE:   req_bus.ready = 1'b1;
         rtlpm_pkg::S_WALK:   capture_en = tok[rtlpm_pkg::TABLE_DEPTH].live;
         // hold the finished result until the response slot frees up
         rtlpm_pkg::S_FINISH: finish_go = !rsp_valid_ff || rsp_bus.ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rtlpm_pkg::S_IDLE;
         start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         // launch the token in the cycle after accept, once the query is registered
         start_ff <= accept;
      end
   end

   // latch the request; interface is clamped here so the finish step compares the stored form
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.func   <= rtlpm_pkg::func_type'(req_bus.func);
         item_ff.key    <= req_bus.key_addr;
         item_ff.mask   <= req_bus.net_mask;
         item_ff.hop    <= req_bus.next_hop;
         item_ff.ifc    <= rtlpm_pkg::sat_iface(req_bus.interface_index);
         item_ff.dyn    <= req_bus.dynamic_flag;
         item_ff.metric <= req_bus.route_metric;
      end
   end

   // ---------------------------------------------------------------------
   // Cell chain: the token visits one route per cycle, keeping the best or first exact match
   // ---------------------------------------------------------------------
   assign query.func  = item_ff.func;
   assign query.key   = item_ff.key;
   assign query.count = count_ff;

   always_comb begin
      tok[0]           = '0;
      tok[0].live      = start_ff;
   end

   assign wr_idx = count_ff[rtlpm_pkg::IDX_W-1:0];

   assign new_entry.subnet = item_ff.key;
   assign new_entry.mask   = item_ff.mask;
   assign new_entry.hop    = item_ff.hop;
   assign new_entry.metric = item_ff.metric;
   assign new_entry.iface  = item_ff.ifc;
   assign new_entry.dyn    = item_ff.dyn;

   for (genvar i = 0; i < rtlpm_pkg::TABLE_DEPTH; i++) begin : g_cell
      rtlpm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .query    (query),
         .wr_en    (wr_en && (wr_idx == rtlpm_pkg::IDX_W'(i))),
         .wr_entry (new_entry),
         .tok_prev (tok[i]),
         .tok_next (tok[i+1])
      );
      assign live_vec[i] = tok[i+1].live;
   end

   // hold the token that leaves the last cell
   always_ff @(posedge clock) begin
      if (capture_en) begin
         done_ff <= tok[rtlpm_pkg::TABLE_DEPTH];
      end
   end

   // ---------------------------------------------------------------------
   // Finish: decide status, append a new insert when there is room, build the response
   // ---------------------------------------------------------------------
   always_comb begin
      append        = 1'b0;
      rsp_in.status = rtlpm_pkg::ST_MISS;
      rsp_in.idx    = '0;
      rsp_in.entry  = '0;
      if (item_ff.func == rtlpm_pkg::FUNC_LOOKUP) begin
         if (done_ff.hit) begin
            rsp_in.status = rtlpm_pkg::ST_HIT;
            rsp_in.idx    = rtlpm_pkg::OUT_IDX_W'(done_ff.hit_idx);
            rsp_in.entry  = done_ff.hit_entry;
         end
      end else if (done_ff.hit && done_ff.hit_entry.iface == item_ff.ifc) begin
         // same subnet on the same interface: report the existing route
         rsp_in.status = rtlpm_pkg::ST_PRESENT;
         rsp_in.idx    = rtlpm_pkg::OUT_IDX_W'(done_ff.hit_idx);
         rsp_in.entry  = done_ff.hit_entry;
      end else if (count_ff >= rtlpm_pkg::COUNT_W'(rtlpm_pkg::TABLE_DEPTH)) begin
         rsp_in.status = rtlpm_pkg::ST_FULL;
      end else begin
         append        = 1'b1;
         rsp_in.status = done_ff.hit ? rtlpm_pkg::ST_CONFLICT : rtlpm_pkg::ST_INSERTED;
         rsp_in.idx    = rtlpm_pkg::OUT_IDX_W'(wr_idx);
         rsp_in.entry  = new_entry;
      end
   end

   assign wr_en = finish_go && append;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            count_ff <= count_ff + 1'b1;
         end
         // advance the response register on load, drop valid when taken
         if (finish_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (finish_go) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_ff.status;
   assign rsp_bus.entry_index = rsp_ff.idx;
   assign rsp_bus.hop_out     = rsp_ff.entry.hop;
   assign rsp_bus.iface_out   = rsp_ff.entry.iface;
   assign rsp_bus.mask_out    = rsp_ff.entry.mask;
   assign rsp_bus.metric_out  = rsp_ff.entry.metric;
   assign rsp_bus.dynamic_out = rsp_ff.entry.dyn;

   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(live_vec))
      else $error("more than one search transaction in the cell chain");

   a_no_accept_in_walk: assert property (@(posedge clock) disable iff (reset)
      (live_vec != '0 || start_ff) |-> !req_bus.ready)
      else $error("request accepted while a search is in flight");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= rtlpm_pkg::COUNT_W'(rtlpm_pkg::TABLE_DEPTH))
      else $error("route count beyond table depth");

   a_count_only_on_append: assert property (@(posedge clock) disable iff (reset)
      !wr_en |=> $stable(count_ff))
      else $error("route count changed without an append");

endmodule
`default_nettype wire

/* design/rtlpm_cell.sv */
`default_nettype none
module rtlpm_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rtlpm_pkg::query_type  query,
   input  wire logic                  wr_en,
   input  wire rtlpm_pkg::entry_type  wr_entry,
   input  wire rtlpm_pkg::token_type  tok_prev,
   output rtlpm_pkg::token_type       tok_next
);

   rtlpm_pkg::entry_type entry_ff;
   rtlpm_pkg::token_type token_ff;
   rtlpm_pkg::token_type token_in;

   logic in_range;
   logic lk_match;
   logic better;
   logic take;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff <= wr_entry;
      end
   end

   always_comb begin
      in_range = rtlpm_pkg::COUNT_W'(tok_prev.pos) < query.count;
      lk_match = (query.key & entry_ff.mask) == (entry_ff.subnet & entry_ff.mask);
      better   = !tok_prev.hit || (entry_ff.mask > tok_prev.hit_entry.mask);
      take     = 1'b0;
      if (tok_prev.live && in_range) begin
         if (query.func == rtlpm_pkg::FUNC_LOOKUP) begin
            take = lk_match && better;
         end else begin
            // first exact subnet wins
            take = (entry_ff.subnet == query.key) && !tok_prev.hit;
         end
      end

      token_in     = tok_prev;
      token_in.pos = tok_prev.pos + 1'b1;
      if (take) begin
         token_in.hit       = 1'b1;
         token_in.hit_idx   = tok_prev.pos;
         token_in.hit_entry = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff.live <= 1'b0;
      end else begin
         token_ff.live <= token_in.live;
      end
      token_ff.pos       <= token_in.pos;
      token_ff.hit       <= token_in.hit;
      token_ff.hit_idx   <= token_in.hit_idx;
      token_ff.hit_entry <= token_in.hit_entry;
   end

   assign tok_next = token_ff;

   a_live_moves: assert property (@(posedge clock) disable iff (reset)
      tok_prev.live |=> token_ff.live)
      else $error("token lost in cell");

   a_hit_sticks: assert property (@(posedge clock) disable iff (reset)
      tok_prev.live && tok_prev.hit |=> token_ff.hit)
      else $error("hit flag dropped in cell");

   a_exact_first: assert property (@(posedge clock) disable iff (reset)
      tok_prev.live && tok_prev.hit && query.func == rtlpm_pkg::FUNC_INSERT
      |=> token_ff.hit_idx == $past(tok_prev.hit_idx))
      else $error("later exact match replaced the first one");

endmodule
`default_nettype wire

/* sim/tb_top.sv */
`default_nettype none
module tb_top;

   localparam int TABLE_DEPTH = rtlpm_pkg::TABLE_DEPTH;
   localparam int IFACE_COUNT = rtlpm_pkg::IFACE_COUNT;
   localparam int ADDR_W      = rtlpm_pkg::ADDR_W;
   localparam int IFACE_W     = rtlpm_pkg::IFACE_W;
   localparam int METRIC_W    = rtlpm_pkg::METRIC_W;
   localparam int OUT_IDX_W   = rtlpm_pkg::OUT_IDX_W;

   // Slowest correct run: ~1700 transactions, each with the largest idle gap on the
   // request side, the full walk through the block and the longest stall on the
   // response side. Allow four times that.
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;
   // keep some room free before the default route goes in, so misses stay reachable
   localparam int EARLY_FILL   = TABLE_DEPTH - 2;

   typedef struct {
      logic [ADDR_W-1:0]   subnet;
      logic [ADDR_W-1:0]   mask;
      logic [ADDR_W-1:0]   hop;
      logic [IFACE_W-1:0]  iface;
      logic                dyn;
      logic [METRIC_W-1:0] metric;
   } route_entry_type;

   typedef struct {
      rtlpm_pkg::func_type func;
      logic [ADDR_W-1:0]   key_addr;
      logic [ADDR_W-1:0]   net_mask;
      logic [ADDR_W-1:0]   next_hop;
      logic [IFACE_W-1:0]  interface_index;
      logic                dynamic_flag;
      logic [METRIC_W-1:0] route_metric;
   } route_req_type;

   typedef struct {
      rtlpm_pkg::status_type status;
      logic [OUT_IDX_W-1:0]  entry_index;
      logic [ADDR_W-1:0]     hop_out;
      logic [IFACE_W-1:0]    iface_out;
      logic [ADDR_W-1:0]     mask_out;
      logic [METRIC_W-1:0]   metric_out;
      logic                  dynamic_out;
   } route_rsp_type;

   // Mirror of the routing table plus the queue of responses it predicts.
   class lpm_scoreboard;
      route_entry_type routes[TABLE_DEPTH];
      int unsigned     route_count;
      route_rsp_type   awaited_rsp[$];
      int unsigned     mismatch_count;

      function new();
         route_count    = 0;
         mismatch_count = 0;
      endfunction

      // Build a response; miss and full carry an all-zero entry.
      function route_rsp_type report(rtlpm_pkg::status_type st, int idx, bit has_entry);
         route_rsp_type r;
         r.status      = st;
         r.entry_index = '0;
         r.hop_out     = '0;
         r.iface_out   = '0;
         r.mask_out    = '0;
         r.metric_out  = '0;
         r.dynamic_out = 1'b0;
         if (has_entry) begin
            r.entry_index = OUT_IDX_W'(idx);
            r.hop_out     = routes[idx].hop;
            r.iface_out   = routes[idx].iface;
            r.mask_out    = routes[idx].mask;
            r.metric_out  = routes[idx].metric;
            r.dynamic_out = routes[idx].dyn;
         end
         return r;
      endfunction

      // Apply one transaction to the mirror and return the response it causes.
      function route_rsp_type resolve(route_req_type q);
         bit                 found;
         int                 best;
         logic [ADDR_W-1:0]  best_mask;
         logic [IFACE_W-1:0] ifc;
         bit                 exact;
         int                 at;
         found     = 0;
         best      = 0;
         best_mask = '0;
         if (q.func == rtlpm_pkg::FUNC_LOOKUP) begin
            // longest mask wins, the earliest entry among equal masks
            for (int i = 0; i < route_count; i++) begin
               if ((q.key_addr & routes[i].mask) == (routes[i].subnet & routes[i].mask)) begin
                  if (!found || routes[i].mask > best_mask) begin
                     found     = 1;
                     best      = i;
                     best_mask = routes[i].mask;
                  end
               end
            end
            if (found) return report(rtlpm_pkg::ST_HIT, best, 1);
            return report(rtlpm_pkg::ST_MISS, 0, 0);
         end
         ifc = q.interface_index;
         if (int'(ifc) >= IFACE_COUNT) ifc = IFACE_W'(IFACE_COUNT - 1);
         exact = 0;
         at    = 0;
         for (int i = 0; i < route_count; i++) begin
            if (!exact && routes[i].subnet == q.key_addr) begin
               exact = 1;
               at    = i;
            end
         end
         if (exact && routes[at].iface == ifc) return report(rtlpm_pkg::ST_PRESENT, at, 1);
         if (route_count >= TABLE_DEPTH) return report(rtlpm_pkg::ST_FULL, 0, 0);
         routes[route_count] = '{subnet: q.key_addr, mask: q.net_mask, hop: q.next_hop,
                                 iface: ifc, dyn: q.dynamic_flag, metric: q.route_metric};
         route_count++;
         if (exact) return report(rtlpm_pkg::ST_CONFLICT, route_count - 1, 1);
         return report(rtlpm_pkg::ST_INSERTED, route_count - 1, 1);
      endfunction

      function void note_request(route_req_type q);
         awaited_rsp.push_back(resolve(q));
      endfunction

      function void check_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
         end
      endfunction

      function void check_response(route_rsp_type got);
         route_rsp_type want;
         if (awaited_rsp.size() == 0) begin
            $error("response with nothing outstanding, status %0d", got.status);
            mismatch_count++;
            return;
         end
         want = awaited_rsp.pop_front();
         check_field("status",      ADDR_W'(want.status),      ADDR_W'(got.status));
         check_field("entry_index", ADDR_W'(want.entry_index), ADDR_W'(got.entry_index));
         check_field("hop_out",     want.hop_out,              got.hop_out);
         check_field("iface_out",   ADDR_W'(want.iface_out),   ADDR_W'(got.iface_out));
         check_field("mask_out",    want.mask_out,             got.mask_out);
         check_field("metric_out",  ADDR_W'(want.metric_out),  ADDR_W'(got.metric_out));
         check_field("dynamic_out", ADDR_W'(want.dynamic_out), ADDR_W'(got.dynamic_out));
      endfunction
   endclass

   logic          clock;
   logic          reset;
   int unsigned   cycle_count = 0;
   bit            send_quiet  = 0;
   lpm_scoreboard tracker     = new();

   rtlpm_req_if req_bus();
   rtlpm_rsp_if rsp_bus();

   routing_table_lpm u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Guard against a hung handshake: stop the run once the cycle budget is gone.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Transaction builders
   // ---------------------------------------------------------------------------

   // Build a lookup with every other field at random; it ignores all but the key, so
   // randomize those anyway to toggle every input bit.
   function automatic route_req_type random_request();
      route_req_type q;
      q.func            = rtlpm_pkg::FUNC_LOOKUP;
      q.key_addr        = $urandom();
      q.net_mask        = $urandom();
      q.next_hop        = $urandom();
      q.interface_index = IFACE_W'($urandom_range(0, 31));
      q.dynamic_flag    = 1'($urandom_range(0, 1));
      q.route_metric    = METRIC_W'($urandom_range(0, 65535));
      return q;
   endfunction

   function automatic route_req_type route_item(rtlpm_pkg::func_type f,
                                                logic [ADDR_W-1:0] key,
                                                logic [ADDR_W-1:0] mask,
                                                logic [ADDR_W-1:0] hop,
                                                logic [IFACE_W-1:0] ifc, logic dyn,
                                                logic [METRIC_W-1:0] metric);
      route_req_type q;
      q = '{func: f, key_addr: key, net_mask: mask, next_hop: hop, interface_index: ifc,
            dynamic_flag: dyn, route_metric: metric};
      return q;
   endfunction

   function automatic logic [ADDR_W-1:0] prefix_mask(int len);
      if (len == 0) return '0;
      return {ADDR_W{1'b1}} << (ADDR_W - len);
   endfunction

   // Insert a fresh route; one in eight gets a scattered (non-contiguous) mask.
   function automatic route_req_type new_route(int min_len);
      route_req_type q;
      q      = random_request();
      q.func = rtlpm_pkg::FUNC_INSERT;
      if ($urandom_range(0, 7) == 0) q.net_mask = $urandom();
      else q.net_mask = prefix_mask($urandom_range(min_len, 32));
      return q;
   endfunction

   // Re-insert a stored subnet, on the same interface or on a different one.
   function automatic route_req_type reuse_route(bit same_iface);
      route_req_type q;
      int            i;
      q      = new_route(0);
      i      = $urandom_range(0, tracker.route_count - 1);
      q.key_addr = tracker.routes[i].subnet;
      if (same_iface) q.interface_index = tracker.routes[i].iface;
      else q.interface_index = IFACE_W'(tracker.routes[i].iface + 1 + $urandom_range(0, 30));
      return q;
   endfunction

   // Aim a lookup at the table: near a stored prefix, on it exactly, near it
   // with one random bit flipped, or anywhere at all.
   function automatic route_req_type probe_lookup();
      route_req_type   q;
      route_entry_type e;
      int              sel;
      q = random_request();
      if (tracker.route_count == 0) return q;
      e   = tracker.routes[$urandom_range(0, tracker.route_count - 1)];
      sel = $urandom_range(0, 19);
      if (sel < 8) q.key_addr = e.subnet ^ ($urandom() & ~e.mask);
      else if (sel < 11) q.key_addr = e.subnet;
      else if (sel < 14)
         q.key_addr = e.subnet ^ ($urandom() & ~e.mask) ^ (32'h1 << $urandom_range(0, 31));
      return q;
   endfunction

   // ---------------------------------------------------------------------------
   // Request driver: idle a random number of cycles (or none during a quiet
   // stretch), present the transaction, hold it until ready, then log it.
   // Keep valid high across back-to-back transactions so it never sees two
   // updates in one time step.
   // ---------------------------------------------------------------------------
   task automatic send_request(route_req_type q);
      int gap;
      if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
      gap = send_quiet ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.func            <= q.func;
      req_bus.key_addr        <= q.key_addr;
      req_bus.net_mask        <= q.net_mask;
      req_bus.next_hop        <= q.next_hop;
      req_bus.interface_index <= q.interface_index;
      req_bus.dynamic_flag    <= q.dynamic_flag;
      req_bus.route_metric    <= q.route_metric;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      tracker.note_request(q);
   endtask

   // ---------------------------------------------------------------------------
   // Response side: stall at random, with quiet stretches of constant ready,
   // and check each accepted transaction against the oldest prediction.
   // ---------------------------------------------------------------------------
   initial begin
      bit            quiet;
      int            stall;
      route_rsp_type got;
      quiet = 0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) quiet = !quiet;
         stall = quiet ? 0 : $urandom_range(0, 18);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (rsp_bus.valid !== 1'b1) @(posedge clock);
         got.status      = rtlpm_pkg::status_type'(rsp_bus.status);
         got.entry_index = rsp_bus.entry_index;
         got.hop_out     = rsp_bus.hop_out;
         got.iface_out   = rsp_bus.iface_out;
         got.mask_out    = rsp_bus.mask_out;
         got.metric_out  = rsp_bus.metric_out;
         got.dynamic_out = rsp_bus.dynamic_out;
         tracker.check_response(got);
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   initial begin
      route_req_type q;
      int            pick;
      reset                   <= 1'b1;
      req_bus.valid           <= 1'b0;
      req_bus.func            <= rtlpm_pkg::FUNC_LOOKUP;
      req_bus.key_addr        <= '0;
      req_bus.net_mask        <= '0;
      req_bus.next_hop        <= '0;
      req_bus.interface_index <= '0;
      req_bus.dynamic_flag    <= 1'b0;
      req_bus.route_metric    <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Empty table: any lookup misses.
      send_request(route_item(rtlpm_pkg::FUNC_LOOKUP, 32'h0000_0000, 32'h0, 32'h0,
                              5'd0, 1'b0, 16'h0));
      send_request(route_item(rtlpm_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF, 5'd31, 1'b1, 16'hFFFF));
      // Nested prefixes /8, /16 and a host route, with field extremes.
      send_request(route_item(rtlpm_pkg::FUNC_INSERT, 32'h0A00_0000, 32'hFF00_0000, 32'h0,
                              5'd0, 1'b0, 16'h0000));
      send_request(route_item(rtlpm_pkg::FUNC_INSERT, 32'h0A01_0000, 32'hFFFF_0000,
                              32'hFFFF_FFFF, 5'd31, 1'b1, 16'hFFFF));
      send_request(route_item(rtlpm_pkg::FUNC_INSERT, 32'h0A01_0203, 32'hFFFF_FFFF,
                              32'hC0A8_0001, 5'd5, 1'b0, 16'h1234));
      // Longest match: host route, then /16, then /8, then nothing.
      send_request(route_item(rtlpm_pkg::FUNC_LOOKUP, 32'h0A01_0203, 32'h0, 32'h0,
                              5'd0, 1'b0, 16'h0));
      send_request(route_item(rtlpm_pkg::FUNC_LOOKUP, 32'h0A01_0909, 32'h0, 32'h0,
                              5'd0, 1'b0, 16'h0));
      send_request(route_item(rtlpm_pkg::FUNC_LOOKUP, 32'h0AC8_0001, 32'h0, 32'h0,
                              5'd0, 1'b0, 16'h0));
      send_request(route_item(rtlpm_pkg::FUNC_LOOKUP, 32'h0B00_0000, 32'h0, 32'h0,
                              5'd0, 1'b0, 16'h0));
      // Same subnet on the same interface: already present.
      send_request(route_item(rtlpm_pkg::FUNC_INSERT, 32'h0A00_0000, 32'hFF00_0000,
                              32'h0101_0101, 5'd0, 1'b1, 16'h0007));
      // Same subnet on another interface: appended with a conflict.
      send_request(route_item(rtlpm_pkg::FUNC_INSERT, 32'h0A00_0000, 32'hFFFF_FF00,
                              32'h0202_0202, 5'd7, 1'b1, 16'h0042));
      send_request(route_item(rtlpm_pkg::FUNC_LOOKUP, 32'h0A00_0005, 32'h0, 32'h0,
                              5'd0, 1'b0, 16'h0));
      // Conflicting /16 with an equal mask: the earlier /16 must still win.
      send_request(route_item(rtlpm_pkg::FUNC_INSERT, 32'h0A01_0000, 32'hFFFF_0000,
                              32'h0303_0303, 5'd3, 1'b0, 16'h0100));
      send_request(route_item(rtlpm_pkg::FUNC_LOOKUP, 32'h0A01_0505, 32'h0, 32'h0,
                              5'd0, 1'b0, 16'h0));
      // Scattered mask: only the masked bits take part in the match.
      send_request(route_item(rtlpm_pkg::FUNC_INSERT, 32'hC0A8_00FF, 32'hFF00_FF00,
                              32'h0A0A_0A0A, 5'd2, 1'b1, 16'h8000));
      send_request(route_item(rtlpm_pkg::FUNC_LOOKUP, 32'hC055_0012, 32'h0, 32'h0,
                              5'd0, 1'b0, 16'h0));
      send_request(route_item(rtlpm_pkg::FUNC_LOOKUP, 32'hC055_0112, 32'h0, 32'h0,
                              5'd0, 1'b0, 16'h0));

      // Grow the table slowly with long prefixes, mixing in re-inserts and
      // lots of lookups while misses are still possible.
      for (int n = 0; n < 600; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 9 && tracker.route_count < EARLY_FILL) q = new_route(8);
         else if (pick < 14 && tracker.route_count < EARLY_FILL)
            q = reuse_route(1'($urandom_range(0, 1)));
         else q = probe_lookup();
         send_request(q);
      end

      // Add a default route, then fill the table to the brim.
      q = new_route(0);
      q.net_mask = '0;
      send_request(q);
      send_request(probe_lookup());
      while (tracker.route_count < TABLE_DEPTH) send_request(new_route(0));

      // Full table: a new route is refused, a duplicate on the same
      // interface is still reported as present, one on another is refused.
      send_request(new_route(0));
      send_request(reuse_route(1));
      send_request(reuse_route(0));

      // Run the full table: mostly lookups, with refused and duplicate inserts.
      for (int n = 0; n < 1050; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) q = new_route(0);
         else if (pick < 14) q = reuse_route(1);
         else if (pick < 20) q = reuse_route(0);
         else q = probe_lookup();
         send_request(q);
      end
      req_bus.valid <= 1'b0;

      // Drain outstanding responses, then give stray ones time to show up.
      while (tracker.awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatch_count == 0 && tracker.awaited_rsp.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
`default_nettype wire
